FILE: hw/rtl/slm_pkg.sv
package slm_pkg;

  // Chunk length in frames; a power of two, so the mean of the squares is a shift.
  localparam int CHUNK_LENGTH = 1024;
  localparam int CHUNK_SHIFT  = $clog2(CHUNK_LENGTH);
  localparam int CNT_W        = $clog2(CHUNK_LENGTH);

  localparam int SMP_W  = 24;
  localparam int SQ_W   = 57;
  localparam int PROD_W = 58;
  localparam int OVF_W  = 11;
  localparam int Q14_W  = 16;

  localparam int QUEUE_DEPTH = 2;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [Q14_W-1:0] ONE_Q14 = 16'd16384;

  // Configuration register indexes.
  localparam logic [1:0] CFG_OVERFLOW_LIMIT = 2'd0;
  localparam logic [1:0] CFG_RMS_FLOOR      = 2'd1;
  localparam logic [1:0] CFG_STEREO_ENABLE  = 2'd2;

  // Accumulated totals of one chunk, handed from the front to the back.
  typedef struct packed {
    logic [SMP_W-1:0]         peak_l;
    logic [SMP_W-1:0]         peak_r;
    logic [SQ_W-1:0]          sq_l;
    logic [SQ_W-1:0]          sq_r;
    logic signed [PROD_W-1:0] prod;
    logic [OVF_W-1:0]         ovf_l;
    logic [OVF_W-1:0]         ovf_r;
  } slm_snap_t;

  // One finished chunk result.
  typedef struct packed {
    logic [SMP_W-1:0] peak_l;
    logic [SMP_W-1:0] peak_r;
    logic [SMP_W-1:0] rms_l;
    logic [SMP_W-1:0] rms_r;
    logic [OVF_W-1:0] ovf_l;
    logic [OVF_W-1:0] ovf_r;
    logic [Q14_W-1:0] corr;
    logic [Q14_W-1:0] bal;
  } slm_result_t;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_RMSL,
    BK_RMSL_W,
    BK_RMSR,
    BK_RMSR_W,
    BK_DECIDE,
    BK_NORM,
    BK_PROD,
    BK_CSQ,
    BK_CSQ_W,
    BK_CDIV,
    BK_CDIV_W,
    BK_BAL,
    BK_BDIV_W,
    BK_OUT
  } slm_bk_state_t;

endpackage

FILE: hw/rtl/slm_front.sv
module slm_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [47:0]                 in_tdata,
  input  logic [slm_pkg::SMP_W-1:0]   overflow_limit,
  input  logic [slm_pkg::QCNT_W-1:0]  q_free,
  output logic                        push,
  output slm_pkg::slm_snap_t          snap
);
  import slm_pkg::*;

  logic signed [SMP_W-1:0] l_s, r_s;
  logic [SMP_W-1:0]        ml, mr;
  logic                    accept, last;

  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  // First stage: magnitudes and products of the accepted frame.
  logic                    s1_valid_r, s1_last_r;
  logic [SMP_W-1:0]        s1_ml_r, s1_mr_r;
  logic [2*SMP_W-1:0]      s1_sql_r, s1_sqr_r;
  logic signed [2*SMP_W-1:0] s1_prod_r;
  logic                    s1_ovl_r, s1_ovr_r;

  // Accumulators of the running chunk.
  logic [SMP_W-1:0]         pk_l_r, pk_r_r, pk_l_nxt, pk_r_nxt;
  logic [SQ_W-1:0]          sq_l_r, sq_r_r, sq_l_nxt, sq_r_nxt;
  logic signed [PROD_W-1:0] pr_r, pr_nxt;
  logic [OVF_W-1:0]         ov_l_r, ov_r_r, ov_l_nxt, ov_r_nxt;

  assign l_s = $signed(in_tdata[23:0]);
  assign r_s = $signed(in_tdata[47:24]);
  assign ml  = l_s[SMP_W-1] ? (~l_s + 1'b1) : l_s;
  assign mr  = r_s[SMP_W-1] ? (~r_s + 1'b1) : r_s;

  // A chunk end in flight needs a free queue slot of its own.
  assign in_tready = q_free > QCNT_W'(s1_valid_r && s1_last_r);
  assign accept    = in_tvalid && in_tready;
  assign last      = cnt_r == CNT_W'(CHUNK_LENGTH - 1);
  assign cnt_nxt   = last ? '0 : cnt_r + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r      <= '0;
      s1_valid_r <= 1'b0;
      s1_last_r  <= 1'b0;
    end else begin
      s1_valid_r <= accept;
      if (accept) begin
        cnt_r     <= cnt_nxt;
        s1_last_r <= last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_ml_r   <= ml;
      s1_mr_r   <= mr;
      s1_sql_r  <= ml * ml;
      s1_sqr_r  <= mr * mr;
      s1_prod_r <= l_s * r_s;
      s1_ovl_r  <= ml > overflow_limit;
      s1_ovr_r  <= mr > overflow_limit;
    end
  end

  // Second stage: fold the frame into the chunk totals.
  always_comb begin
    pk_l_nxt = (s1_ml_r > pk_l_r) ? s1_ml_r : pk_l_r;
    pk_r_nxt = (s1_mr_r > pk_r_r) ? s1_mr_r : pk_r_r;
    sq_l_nxt = sq_l_r + SQ_W'(s1_sql_r);
    sq_r_nxt = sq_r_r + SQ_W'(s1_sqr_r);
    pr_nxt   = pr_r + {{(PROD_W-2*SMP_W){s1_prod_r[2*SMP_W-1]}}, s1_prod_r};
    ov_l_nxt = (s1_ovl_r && ov_l_r != '1) ? ov_l_r + 1'b1 : ov_l_r;
    ov_r_nxt = (s1_ovr_r && ov_r_r != '1) ? ov_r_r + 1'b1 : ov_r_r;
  end

  assign push        = s1_valid_r && s1_last_r;
  assign snap.peak_l = pk_l_nxt;
  assign snap.peak_r = pk_r_nxt;
  assign snap.sq_l   = sq_l_nxt;
  assign snap.sq_r   = sq_r_nxt;
  assign snap.prod   = pr_nxt;
  assign snap.ovf_l  = ov_l_nxt;
  assign snap.ovf_r  = ov_r_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n || push) begin
      pk_l_r <= '0;
      pk_r_r <= '0;
      sq_l_r <= '0;
      sq_r_r <= '0;
      pr_r   <= '0;
      ov_l_r <= '0;
      ov_r_r <= '0;
    end else if (s1_valid_r) begin
      pk_l_r <= pk_l_nxt;
      pk_r_r <= pk_r_nxt;
      sq_l_r <= sq_l_nxt;
      sq_r_r <= sq_r_nxt;
      pr_r   <= pr_nxt;
      ov_l_r <= ov_l_nxt;
      ov_r_r <= ov_r_nxt;
    end
  end

endmodule

FILE: hw/rtl/slm_queue.sv
module slm_queue (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        push,
  input  slm_pkg::slm_snap_t          push_data,
  input  logic                        pop,
  output logic                        not_empty,
  output slm_pkg::slm_snap_t          head,
  output logic [slm_pkg::QCNT_W-1:0]  free
);
  import slm_pkg::*;

  slm_snap_t            slot_r [QUEUE_DEPTH];
  logic                 wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0]    count_r;

  assign not_empty = count_r != '0;
  assign head      = slot_r[rd_ptr_r];
  assign free      = QCNT_W'(QUEUE_DEPTH) - count_r;

  // Two-entry queue of chunk totals; pointers wrap naturally.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop) rd_ptr_r <= ~rd_ptr_r;
      count_r <= count_r + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= push_data;
  end

endmodule

FILE: hw/rtl/slm_isqrt.sv
module slm_isqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] arg,
  output logic        done,
  output logic [31:0] root
);
  import slm_pkg::*;

  logic [63:0] v_r, r_r, bit_r, tsum;
  logic [4:0]  step_r;
  logic        busy_r, done_r;

  assign tsum = r_r + bit_r;
  assign done = done_r;
  assign root = r_r[31:0];

  // One result bit per cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= busy_r && step_r == '1;
      if (start) busy_r <= 1'b1;
      else if (step_r == '1) busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      v_r    <= arg;
      r_r    <= '0;
      bit_r  <= 64'h4000_0000_0000_0000;
      step_r <= '0;
    end else if (busy_r) begin
      if (v_r >= tsum) begin
        v_r <= v_r - tsum;
        r_r <= (r_r >> 1) + bit_r;
      end else begin
        r_r <= r_r >> 1;
      end
      bit_r  <= bit_r >> 2;
      step_r <= step_r + 1'b1;
    end
  end

endmodule

FILE: hw/rtl/slm_div.sv
module slm_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [71:0]                 num,
  input  logic [31:0]                 den,
  output logic                        done,
  output logic [slm_pkg::Q14_W-1:0]   quo
);
  import slm_pkg::*;

  logic [71:0]      num_r;
  logic [31:0]      den_r;
  logic [32:0]      rem_r, rem_t;
  logic [Q14_W-1:0] q_r;
  logic             sat_r, ge;
  logic [6:0]       cnt_r;
  logic             busy_r, done_r, last;

  assign rem_t = {rem_r[31:0], num_r[71]};
  assign ge    = rem_t >= {1'b0, den_r};
  assign last  = cnt_r == 7'd71;
  assign done  = done_r;
  // Quotients past one are clamped to one.
  assign quo   = (sat_r || q_r > ONE_Q14) ? ONE_Q14 : q_r;

  // Restoring division, one quotient bit per cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= busy_r && last;
      if (start) busy_r <= 1'b1;
      else if (last) busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= num;
      den_r <= den;
      rem_r <= '0;
      q_r   <= '0;
      sat_r <= 1'b0;
      cnt_r <= '0;
    end else if (busy_r) begin
      num_r <= num_r << 1;
      rem_r <= ge ? rem_t - {1'b0, den_r} : rem_t;
      q_r   <= {q_r[Q14_W-2:0], ge};
      sat_r <= sat_r | q_r[Q14_W-1];
      cnt_r <= cnt_r + 1'b1;
    end
  end

endmodule

FILE: hw/rtl/slm_back.sv
module slm_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       q_not_empty,
  input  slm_pkg::slm_snap_t         q_head,
  output logic                       pop,
  input  logic [slm_pkg::SMP_W-1:0]  rms_floor,
  input  logic                       stereo_enable,
  output logic                       res_valid,
  input  logic                       res_ready,
  output slm_pkg::slm_result_t       res
);
  import slm_pkg::*;

  slm_bk_state_t state_r, state_nxt;

  slm_snap_t            w_r;
  logic [SMP_W-1:0]     rms_l_r, rms_r_r;
  logic [SQ_W-1:0]      a_s_r, b_s_r;
  logic [4:0]           ka_r, kb_r;
  logic [59:0]          cprod_r;
  logic [PROD_W-1:0]    pm_r;
  logic [31:0]          d_r;
  logic [Q14_W-1:0]     corr_r, bal_r;
  logic                 bal_sw_r;
  logic                 res_valid_r;
  slm_result_t          res_r;

  logic a_big, b_big, silent, out_free, odd;
  logic [5:0]           ksum;
  logic [PROD_W-1:0]    pabs;

  logic        sq_start, sq_done, dv_start, dv_done;
  logic [63:0] sq_arg;
  logic [31:0] sq_root, dv_den;
  logic [71:0] dv_num;
  logic [Q14_W-1:0] dv_quo;

  slm_isqrt u_isqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sq_start),
    .arg   (sq_arg),
    .done  (sq_done),
    .root  (sq_root)
  );

  slm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (dv_start),
    .num   (dv_num),
    .den   (dv_den),
    .done  (dv_done),
    .quo   (dv_quo)
  );

  assign a_big    = |a_s_r[SQ_W-1:30];
  assign b_big    = |b_s_r[SQ_W-1:30];
  assign ksum     = 6'(ka_r) + 6'(kb_r);
  assign odd      = ksum[0];
  assign silent   = rms_l_r < rms_floor && rms_r_r < rms_floor;
  assign out_free = !res_valid_r || res_ready;
  assign pabs     = w_r.prod[PROD_W-1] ? (~w_r.prod + 1'b1) : w_r.prod;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE:   if (q_not_empty) state_nxt = BK_RMSL;
      BK_RMSL:   state_nxt = BK_RMSL_W;
      BK_RMSL_W: if (sq_done) state_nxt = BK_RMSR;
      BK_RMSR:   state_nxt = BK_RMSR_W;
      BK_RMSR_W: if (sq_done) state_nxt = BK_DECIDE;
      BK_DECIDE: begin
        if (!stereo_enable || silent) state_nxt = BK_OUT;
        else if (w_r.sq_l != '0 && w_r.sq_r != '0) state_nxt = BK_NORM;
        else state_nxt = BK_BAL;
      end
      BK_NORM:   if (!a_big && !b_big) state_nxt = BK_PROD;
      BK_PROD:   state_nxt = BK_CSQ;
      BK_CSQ:    state_nxt = BK_CSQ_W;
      BK_CSQ_W:  if (sq_done) state_nxt = (sq_root == '0) ? BK_BAL : BK_CDIV;
      BK_CDIV:   state_nxt = BK_CDIV_W;
      BK_CDIV_W: if (dv_done) state_nxt = BK_BAL;
      BK_BAL: begin
        if (rms_r_r >= rms_l_r && rms_r_r == '0) state_nxt = BK_OUT;
        else state_nxt = BK_BDIV_W;
      end
      BK_BDIV_W: if (dv_done) state_nxt = BK_OUT;
      BK_OUT:    if (out_free) state_nxt = BK_IDLE;
      default:   state_nxt = BK_IDLE;
    endcase
  end

  // Unit controls and operand selection.
  always_comb begin
    pop      = 1'b0;
    sq_start = 1'b0;
    sq_arg   = 64'(w_r.sq_l >> CHUNK_SHIFT);
    dv_start = 1'b0;
    dv_num   = {pm_r, 14'b0} + 72'(d_r >> 1);
    dv_den   = d_r;
    case (state_r)
      BK_IDLE: pop = q_not_empty;
      BK_RMSL: sq_start = 1'b1;
      BK_RMSR: begin
        sq_start = 1'b1;
        sq_arg   = 64'(w_r.sq_r >> CHUNK_SHIFT);
      end
      BK_CSQ: begin
        sq_start = 1'b1;
        sq_arg   = 64'(cprod_r);
      end
      BK_CDIV: dv_start = 1'b1;
      BK_BAL: begin
        if (rms_r_r >= rms_l_r) begin
          dv_start = rms_r_r != '0;
          dv_num   = 72'({rms_l_r, 14'b0}) + 72'(rms_r_r >> 1);
          dv_den   = 32'(rms_r_r);
        end else begin
          dv_start = 1'b1;
          dv_num   = 72'({rms_r_r, 14'b0}) + 72'(rms_l_r >> 1);
          dv_den   = 32'(rms_l_r);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= BK_IDLE;
    else state_r <= state_nxt;
  end

  // Working registers of the chunk under computation.
  always_ff @(posedge clk) begin
    case (state_r)
      BK_IDLE: begin
        w_r    <= q_head;
        a_s_r  <= q_head.sq_l;
        b_s_r  <= q_head.sq_r;
        ka_r   <= '0;
        kb_r   <= '0;
        corr_r <= ONE_Q14;
        bal_r  <= '0;
      end
      BK_RMSL_W: if (sq_done) rms_l_r <= sq_root[SMP_W-1:0];
      BK_RMSR_W: if (sq_done) rms_r_r <= sq_root[SMP_W-1:0];
      BK_NORM: begin
        // Bring both sums under 30 bits, then make the total shift even.
        if (a_big || b_big) begin
          if (a_big) begin
            a_s_r <= a_s_r >> 1;
            ka_r  <= ka_r + 1'b1;
          end
          if (b_big) begin
            b_s_r <= b_s_r >> 1;
            kb_r  <= kb_r + 1'b1;
          end
        end else if (odd) begin
          if (ka_r >= kb_r) begin
            a_s_r <= a_s_r >> 1;
            ka_r  <= ka_r + 1'b1;
          end else begin
            b_s_r <= b_s_r >> 1;
            kb_r  <= kb_r + 1'b1;
          end
        end
      end
      BK_PROD: begin
        cprod_r <= a_s_r[29:0] * b_s_r[29:0];
        pm_r    <= pabs >> ksum[5:1];
      end
      BK_CSQ_W: if (sq_done) d_r <= sq_root;
      BK_CDIV_W: begin
        if (dv_done) corr_r <= w_r.prod[PROD_W-1] ? (~dv_quo + 1'b1) : dv_quo;
      end
      BK_BAL: bal_sw_r <= rms_r_r < rms_l_r;
      BK_BDIV_W: begin
        if (dv_done) bal_r <= bal_sw_r ? dv_quo - ONE_Q14 : ONE_Q14 - dv_quo;
      end
      default: ;
    endcase
  end

  // Output register; a waiting result does not hold up the next chunk.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else if (state_r == BK_OUT && out_free) begin
      res_valid_r <= 1'b1;
    end else if (res_ready) begin
      res_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == BK_OUT && out_free) begin
      res_r.peak_l <= w_r.peak_l;
      res_r.peak_r <= w_r.peak_r;
      res_r.rms_l  <= rms_l_r;
      res_r.rms_r  <= rms_r_r;
      res_r.ovf_l  <= w_r.ovf_l;
      res_r.ovf_r  <= w_r.ovf_r;
      res_r.corr   <= corr_r;
      res_r.bal    <= bal_r;
    end
  end

  assign res_valid = res_valid_r;
  assign res       = res_r;

endmodule

FILE: hw/rtl/stereo_chunk_level_meter_top.sv
// Stereo chunk level meter. Frames of two signed Q1.23 samples are taken one per cycle;
// after every CHUNK_LENGTH frames one result carries peak, RMS and overflow count per
// channel, plus phase correlation and stereo balance in Q1.14. The accumulating front
// takes a frame every cycle; the end-of-chunk math runs in a sequential back part
// (three square roots, two divisions, a normalizing loop and single control states),
// and a two-entry queue holds chunk totals in between. Input stalls only when the
// queue is full: when chunks are shorter than the back part's time, or when results
// are not taken and the result register, the back part and the queue all hold
// finished chunks. The result register lets the next chunk be computed while a
// result waits to be taken. Configuration must be written while idle; the block
// itself does not enforce it.
module stereo_chunk_level_meter_top (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [47:0]   in_tdata,   // left_sample[23:0], right_sample[47:24]
  output logic          out_tvalid,
  input  logic          out_tready,
  // peak_left[23:0], peak_right[47:24], rms_left[71:48], rms_right[95:72],
  // overflow_count_left[106:96], overflow_count_right[117:107],
  // phase_correlation[133:118], stereo_balance[149:134], zero pad[151:150]
  output logic [151:0]  out_tdata,
  input  logic          cfg_we,
  input  logic [1:0]    cfg_index,
  input  logic [23:0]   cfg_wdata
);
  import slm_pkg::*;

  logic [SMP_W-1:0]  ovf_limit_r, rms_floor_r;
  logic              stereo_en_r;
  logic              push, pop, q_not_empty;
  slm_snap_t         snap, q_head;
  logic [QCNT_W-1:0] q_free;
  slm_result_t       res;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovf_limit_r <= 24'd8387769;
      rms_floor_r <= 24'd839;
      stereo_en_r <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_OVERFLOW_LIMIT: ovf_limit_r <= cfg_wdata;
        CFG_RMS_FLOOR:      rms_floor_r <= cfg_wdata;
        CFG_STEREO_ENABLE:  stereo_en_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  slm_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .overflow_limit (ovf_limit_r),
    .q_free         (q_free),
    .push           (push),
    .snap           (snap)
  );

  slm_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (snap),
    .pop       (pop),
    .not_empty (q_not_empty),
    .head      (q_head),
    .free      (q_free)
  );

  slm_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_not_empty   (q_not_empty),
    .q_head        (q_head),
    .pop           (pop),
    .rms_floor     (rms_floor_r),
    .stereo_enable (stereo_en_r),
    .res_valid     (out_tvalid),
    .res_ready     (out_tready),
    .res           (res)
  );

  assign out_tdata = {2'b00, res.bal, res.corr, res.ovf_r, res.ovf_l,
                      res.rms_r, res.rms_l, res.peak_r, res.peak_l};

endmodule

FILE: hw/rtl/slm_checker.sv
module slm_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          out_tvalid,
  input logic          out_tready,
  input logic [151:0]  out_tdata
);

  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // RMS never exceeds the peak of the same channel.
  a_rms_l: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[71:48] <= out_tdata[23:0])
    else $error("left rms above left peak");

  a_rms_r: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[95:72] <= out_tdata[47:24])
    else $error("right rms above right peak");

  // Correlation and balance stay within plus and minus one.
  a_corr: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(out_tdata[133:118]) <= 16'sd16384 &&
                    $signed(out_tdata[133:118]) >= -16'sd16384))
    else $error("correlation out of range");

  a_bal: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(out_tdata[149:134]) <= 16'sd16384 &&
                    $signed(out_tdata[149:134]) >= -16'sd16384))
    else $error("balance out of range");

endmodule

bind stereo_chunk_level_meter_top slm_checker u_slm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
